// File: sv/jsqd_pkg.sv
// Package for the join-shortest-queue dispatcher.
// Holds the field types, sizing constants and operation/status codes.
// No dependencies; jsqd_if.sv and the dispatcher use it, jsqd_ram does not.
`default_nettype none

package jsqd_pkg;

    localparam int NUM_QUEUES  = 4;
    localparam int QUEUE_DEPTH = 16;

    localparam int QW         = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW         = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE_SIZE = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW         = $clog2(STORE_SIZE);

    // Transfer payload field types.
    typedef logic        t_op;
    typedef logic [15:0] t_id;
    typedef logic [1:0]  t_qidx;
    typedef logic [4:0]  t_len;
    typedef logic [1:0]  t_status;

    // Internal types.
    typedef logic [QW-1:0] t_qnum;
    typedef logic [PW-1:0] t_ptr;
    typedef logic [CW-1:0] t_cnt;
    typedef logic [AW-1:0] t_addr;

    localparam t_op OP_ARRIVE = 1'b0;
    localparam t_op OP_DEPART = 1'b1;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

// File: sv/jsqd_if.sv
// Valid/ready channel interfaces for the dispatcher's input and result streams.
// Depends on jsqd_pkg for the payload field types.
`default_nettype none

interface jsqd_in_if;
    logic                  valid;
    logic                  ready;
    jsqd_pkg::t_op         operation;
    jsqd_pkg::t_id         customer_id;
    jsqd_pkg::t_qidx       queue_select;

    modport source (output valid, output operation, output customer_id,
                    output queue_select, input ready);
    modport sink   (input valid, input operation, input customer_id,
                    input queue_select, output ready);
endinterface

interface jsqd_out_if;
    logic                  valid;
    logic                  ready;
    jsqd_pkg::t_qidx       queue_index;
    jsqd_pkg::t_id         served_id;
    jsqd_pkg::t_len        queue_length;
    jsqd_pkg::t_status     status;

    modport source (output valid, output queue_index, output served_id,
                    output queue_length, output status, input ready);
    modport sink   (input valid, input queue_index, input served_id,
                    input queue_length, input status, output ready);
endinterface

`default_nettype wire

// File: sv/jsqd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependency.
`default_nettype none

module jsqd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/join_shortest_queue_dispatcher_unit.sv
// Join-shortest-queue dispatcher: NUM_QUEUES bounded FIFOs of customer ids in one RAM.
// Each input transfer is registered in stage 1, then in the output register that drives
// the result; one item per cycle is sustained while results are taken.
// Reset (synchronous, active low) clears all lengths, head pointers and valid flags;
// the id store is not cleared and is only ever read at entries already written.
// Depends on jsqd_pkg, jsqd_if.sv and jsqd_ram.
`default_nettype none

module join_shortest_queue_dispatcher_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    jsqd_in_if.sink   i_in,
    jsqd_out_if.source o_out
);
    import jsqd_pkg::*;

    // Per-queue state.
    t_cnt r_cnt  [NUM_QUEUES];
    t_ptr r_head [NUM_QUEUES];
    t_cnt n_cnt  [NUM_QUEUES];
    t_ptr n_head [NUM_QUEUES];

    // Stage 1: decided result, waiting for RAM read data on departures.
    logic    r_s1_valid;
    logic    r_s1_use_ram;
    t_qidx   r_s1_qidx;
    t_id     r_s1_id;
    t_len    r_s1_len;
    t_status r_s1_status;

    // Output register.
    logic    r_o_valid;
    t_qidx   r_o_qidx;
    t_id     r_o_id;
    t_len    r_o_len;
    t_status r_o_status;

    logic    in_xfer;
    logic    s1_move;
    t_qnum   best;
    t_qnum   sel;
    logic    sel_ok;
    logic    arr_full;
    logic    dep_empty;
    logic [PW:0] slot_sum;
    t_ptr    tail_slot;
    t_ptr    head_next;

    logic    ram_we;
    logic    ram_re;
    t_addr   ram_waddr;
    t_addr   ram_raddr;
    t_id     ram_rdata;

    logic    n_s1_use_ram;
    t_qidx   n_s1_qidx;
    t_id     n_s1_id;
    t_len    n_s1_len;
    t_status n_s1_status;

    assign s1_move  = r_s1_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_move;
    assign in_xfer  = i_in.valid && i_in.ready;

    // Shortest queue, lowest index on a tie.
    always_comb begin
        best = '0;
        for (int q = 1; q < NUM_QUEUES; q++) begin
            if (r_cnt[q] < r_cnt[best]) begin
                best = QW'(q);
            end
        end
    end

    assign sel       = QW'(i_in.queue_select);
    assign sel_ok    = (int'(i_in.queue_select) < NUM_QUEUES);
    assign arr_full  = (r_cnt[best] >= CW'(QUEUE_DEPTH));
    assign dep_empty = !sel_ok || (r_cnt[sel] == '0);

    // Tail slot wraps inside the queue's region of the store.
    assign slot_sum  = {1'b0, r_head[best]} + (PW + 1)'(r_cnt[best]);
    assign tail_slot = (slot_sum >= (PW + 1)'(QUEUE_DEPTH))
                       ? PW'(slot_sum - (PW + 1)'(QUEUE_DEPTH)) : PW'(slot_sum);
    assign head_next = (r_head[sel] == PW'(QUEUE_DEPTH - 1)) ? '0 : r_head[sel] + PW'(1);

    assign ram_we    = in_xfer && (i_in.operation == OP_ARRIVE) && !arr_full;
    assign ram_re    = in_xfer && (i_in.operation == OP_DEPART) && !dep_empty;
    assign ram_waddr = AW'(best) * AW'(QUEUE_DEPTH) + AW'(tail_slot);
    assign ram_raddr = AW'(sel) * AW'(QUEUE_DEPTH) + AW'(r_head[sel]);

    always_comb begin
        for (int q = 0; q < NUM_QUEUES; q++) begin
            n_cnt[q]  = r_cnt[q];
            n_head[q] = r_head[q];
        end
        n_s1_use_ram = 1'b0;
        n_s1_qidx    = '0;
        n_s1_id      = i_in.customer_id;
        n_s1_len     = t_len'(QUEUE_DEPTH);
        n_s1_status  = ST_FULL;

        if (i_in.operation == OP_ARRIVE) begin
            if (!arr_full) begin
                n_cnt[best] = r_cnt[best] + CW'(1);
                n_s1_qidx   = t_qidx'(best);
                n_s1_len    = t_len'(r_cnt[best] + CW'(1));
                n_s1_status = ST_OK;
            end
        end else begin
            n_s1_qidx = i_in.queue_select;
            if (dep_empty) begin
                n_s1_id     = '0;
                n_s1_len    = '0;
                n_s1_status = ST_EMPTY;
            end else begin
                n_cnt[sel]   = r_cnt[sel] - CW'(1);
                n_head[sel]  = head_next;
                n_s1_use_ram = 1'b1;
                n_s1_len     = t_len'(r_cnt[sel] - CW'(1));
                n_s1_status  = ST_OK;
            end
        end
    end

    jsqd_ram #(
        .WIDTH ($bits(t_id)),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in.customer_id),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_cnt[q]  <= '0;
                r_head[q] <= '0;
            end
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (in_xfer) begin
                for (int q = 0; q < NUM_QUEUES; q++) begin
                    r_cnt[q]  <= n_cnt[q];
                    r_head[q] <= n_head[q];
                end
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_move) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_use_ram <= n_s1_use_ram;
            r_s1_qidx    <= n_s1_qidx;
            r_s1_id      <= n_s1_id;
            r_s1_len     <= n_s1_len;
            r_s1_status  <= n_s1_status;
        end
        // RAM read data stays put while stage 1 waits, since no new item is taken then.
        if (s1_move) begin
            r_o_qidx   <= r_s1_qidx;
            r_o_id     <= r_s1_use_ram ? ram_rdata : r_s1_id;
            r_o_len    <= r_s1_len;
            r_o_status <= r_s1_status;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.queue_index  = r_o_qidx;
    assign o_out.served_id    = r_o_id;
    assign o_out.queue_length = r_o_len;
    assign o_out.status       = r_o_status;

endmodule

`default_nettype wire
